// File: rtl/brb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// brb_pkg
// Shared types and constants of the circular byte buffer.
// ----------------------------------------------------------------------------
package brb_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned DATA_W  = 64;
  localparam int unsigned LEN_W   = 13;
  localparam int unsigned CNT_W   = 13;
  localparam int unsigned IDX_W   = 12;
  localparam int unsigned OP_W    = 3;
  localparam int unsigned LIDX_W  = 3;   // lane index, up to eight lanes
  localparam int unsigned APB_DW  = 32;
  localparam int unsigned PADDR_W = 3;

  // register index, taken from paddr[PADDR_W-1:2]
  localparam logic REG_BUF_SIZE = 1'b0;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE   = 3'd0,
    OP_READ    = 3'd1,
    OP_DISCARD = 3'd2,
    OP_ADVANCE = 3'd3,
    OP_CLEAR   = 3'd4
  } op_e;

  // store access for one request
  typedef struct packed {
    logic       wr;
    logic       rd;
    logic [3:0] cnt;     // bytes moved
    logic [3:0] run_a;   // bytes before the pointer wraps
  } acc_t;

  // status reported with each result
  typedef struct packed {
    logic             ok;
    logic [CNT_W-1:0] rd_tot;
    logic [CNT_W-1:0] wr_tot;
    logic [CNT_W-1:0] rd_lin;
    logic [CNT_W-1:0] wr_lin;
    logic [IDX_W-1:0] rd_idx;
    logic [IDX_W-1:0] wr_idx;
  } stat_t;

endpackage
`default_nettype wire

// File: rtl/brb_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// brb_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module brb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// File: rtl/brb_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// brb_ctrl
// Pointers, fill count, size register and per-request decision.
// ----------------------------------------------------------------------------
module brb_ctrl import brb_pkg::*; #(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned LANES = 8
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [OP_W-1:0]          op_i,
  input  logic [LEN_W-1:0]         length_i,
  input  logic                     consume_i,
  input  logic                     cfg_we_i,
  input  logic [LEN_W-1:0]         cfg_data_i,
  output logic [LEN_W-1:0]         buf_size_o,
  output acc_t                     plan_o,
  output logic [$clog2(DEPTH)-1:0] base_o,
  output logic                     done_o,
  output stat_t                    stat_o
);

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned LW = (CW > LEN_W) ? CW : LEN_W;

  logic [PW-1:0]    rp_q, rp_d, wp_q, wp_d;
  logic [CW-1:0]    fill_q, fill_d, size_q, size_d;
  logic [LEN_W-1:0] bsz_q, bsz_d;
  logic             done_q, ok_q, ok_d;

  logic [LW-1:0] len_w, fill_w, free_w, cfg_w;
  logic [CW-1:0] free_c, amt, room, rd_room, wr_room;
  logic [PW-1:0] ptr, wrapped;
  logic [CW:0]   sum;
  logic          fits_lanes, wr_side;
  acc_t          plan;

  // shared wrap adder
  always_comb begin
    free_c     = size_q - fill_q;
    len_w      = LW'(length_i);
    fill_w     = LW'(fill_q);
    free_w     = LW'(free_c);
    fits_lanes = len_w <= LW'(LANES);
    wr_side    = (op_i == OP_WRITE) || (op_i == OP_ADVANCE);
    ptr        = wr_side ? wp_q : rp_q;

    case (op_i)
      OP_WRITE, OP_READ: amt = CW'(length_i);
      OP_DISCARD:        amt = (len_w < fill_w) ? CW'(length_i) : fill_q;
      OP_ADVANCE:        amt = (len_w < free_w) ? CW'(length_i) : free_c;
      default:           amt = '0;
    endcase

    sum = (CW + 1)'(ptr) + (CW + 1)'(amt);
    if (sum >= (CW + 1)'(size_q)) begin
      wrapped = PW'(sum - (CW + 1)'(size_q));
    end else begin
      wrapped = PW'(sum);
    end
    room = size_q - CW'(ptr);
  end

  always_comb begin
    rp_d  = rp_q;
    wp_d  = wp_q;
    fill_d = fill_q;
    size_d = size_q;
    bsz_d = bsz_q;
    ok_d  = 1'b0;
    plan.wr    = 1'b0;
    plan.rd    = 1'b0;
    plan.cnt   = 4'(length_i);
    plan.run_a = (LW'(room) < len_w) ? 4'(room) : 4'(length_i);

    if (start_i) begin
      case (op_i)
        OP_WRITE: begin
          if (fits_lanes && (len_w <= free_w)) begin
            ok_d    = 1'b1;
            plan.wr = 1'b1;
            wp_d    = wrapped;
            fill_d  = fill_q + amt;
          end
        end
        OP_READ: begin
          if (fits_lanes && (len_w <= fill_w)) begin
            ok_d    = 1'b1;
            plan.rd = 1'b1;
            if (consume_i) begin
              rp_d   = wrapped;
              fill_d = fill_q - amt;
            end
          end
        end
        OP_DISCARD: begin
          ok_d   = 1'b1;
          rp_d   = wrapped;
          fill_d = fill_q - amt;
        end
        OP_ADVANCE: begin
          ok_d   = 1'b1;
          wp_d   = wrapped;
          fill_d = fill_q + amt;
        end
        OP_CLEAR: begin
          ok_d   = 1'b1;
          rp_d   = '0;
          wp_d   = '0;
          fill_d = '0;
        end
        default: begin
          ok_d = 1'b0;
        end
      endcase
    end

    // size write empties the buffer; size 0 acts as 1, oversize as DEPTH
    cfg_w = LW'(cfg_data_i);
    if (cfg_we_i) begin
      bsz_d  = cfg_data_i;
      rp_d   = '0;
      wp_d   = '0;
      fill_d = '0;
      if (cfg_data_i == '0) begin
        size_d = CW'(1);
      end else if (cfg_w > LW'(DEPTH)) begin
        size_d = CW'(DEPTH);
      end else begin
        size_d = CW'(cfg_data_i);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rp_q   <= '0;
      wp_q   <= '0;
      fill_q <= '0;
      size_q <= CW'(DEPTH);
      bsz_q  <= LEN_W'(DEPTH);
      done_q <= 1'b0;
      ok_q   <= 1'b0;
    end else begin
      rp_q   <= rp_d;
      wp_q   <= wp_d;
      fill_q <= fill_d;
      size_q <= size_d;
      bsz_q  <= bsz_d;
      done_q <= start_i;
      ok_q   <= ok_d;
    end
  end

  // status after the request, from the updated state
  always_comb begin
    rd_room = size_q - CW'(rp_q);
    wr_room = size_q - CW'(wp_q);
    stat_o.ok     = ok_q;
    stat_o.rd_tot = CNT_W'(fill_q);
    stat_o.wr_tot = CNT_W'(size_q - fill_q);
    stat_o.rd_lin = CNT_W'((rd_room < fill_q) ? rd_room : fill_q);
    stat_o.wr_lin = CNT_W'((wr_room < (size_q - fill_q)) ? wr_room : (size_q - fill_q));
    stat_o.rd_idx = IDX_W'(rp_q);
    stat_o.wr_idx = IDX_W'(wp_q);
  end

  assign plan_o     = plan;
  assign base_o     = ptr;
  assign done_o     = done_q;
  assign buf_size_o = bsz_q;

endmodule
`default_nettype wire

// File: rtl/brb_store.sv
`default_nettype none
// ----------------------------------------------------------------------------
// brb_store
// Byte store: banked RAMs for the body, flops for the first bank-row, and
// lane routing for writes and reads.
// ----------------------------------------------------------------------------
module brb_store import brb_pkg::*; #(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned LANES = 8
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  acc_t                     plan_i,
  input  logic [$clog2(DEPTH)-1:0] base_i,
  input  logic [DATA_W-1:0]        data_in_i,
  output logic [DATA_W-1:0]        rdata_o
);

  localparam int unsigned PW   = $clog2(DEPTH);
  localparam int unsigned NB   = (LANES > 4) ? 8 : (LANES > 2) ? 4 : (LANES > 1) ? 2 : 1;
  localparam int unsigned LBW  = (NB > 1) ? $clog2(NB) : 1;
  localparam int unsigned ROWS = (DEPTH + NB - 1) / NB;
  localparam int unsigned RW   = $clog2(ROWS);

  // positions below NB live in flops: a wrapped run restarts at 0 and
  // would otherwise hit the same bank as the tail of the first run
  logic [BYTE_W-1:0] head_q [NB];
  logic              head_we   [NB];
  logic [LIDX_W-1:0] head_lane [NB];
  logic [PW-1:0]     head_da   [NB];
  logic              head_a    [NB];

  logic [PW-1:0]     pos [LANES];

  logic [LIDX_W-1:0] bank_lane [NB];
  logic [PW-1:0]     bank_pos  [NB];
  logic              bank_act  [NB];
  logic [RW-1:0]     bank_row  [NB];
  logic [BYTE_W-1:0] bank_wd   [NB];
  logic [BYTE_W-1:0] bank_rd   [NB];

  logic              rd_on_q   [LANES];
  logic              rd_head_q [LANES];
  logic [BYTE_W-1:0] rd_hbyte_q [LANES];
  logic [LBW-1:0]    rd_bsel_q [LANES];

  // lane i -> store position
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      if (4'(i) < plan_i.run_a) begin
        pos[i] = base_i + PW'(i);
      end else begin
        pos[i] = PW'(i) - PW'(plan_i.run_a);
      end
    end
  end

  // head position j <- lane, from either run
  always_comb begin
    for (int j = 0; j < NB; j++) begin
      head_da[j]   = PW'(j) - base_i;
      head_a[j]    = (base_i <= PW'(j)) && (head_da[j] < PW'(plan_i.run_a));
      head_we[j]   = plan_i.wr &&
                     (head_a[j] || (4'(j) < (plan_i.cnt - plan_i.run_a)));
      head_lane[j] = head_a[j] ? LIDX_W'(head_da[j]) : LIDX_W'(4'(j) + plan_i.run_a);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < NB; j++) begin
      if (head_we[j]) begin
        head_q[j] <= data_in_i[head_lane[j]*BYTE_W +: BYTE_W];
      end
    end
  end

  // bank k -> the one lane of the first run that lands in it
  always_comb begin
    for (int k = 0; k < NB; k++) begin
      bank_lane[k] = LIDX_W'((k + NB - (base_i % NB)) % NB);
      bank_pos[k]  = base_i + PW'(bank_lane[k]);
      bank_act[k]  = (4'(bank_lane[k]) < plan_i.run_a) && (bank_pos[k] >= PW'(NB));
      bank_row[k]  = RW'(bank_pos[k] / NB);
      bank_wd[k]   = data_in_i[bank_lane[k]*BYTE_W +: BYTE_W];
    end
  end

  for (genvar k = 0; k < NB; k++) begin : g_bank
    brb_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (ROWS)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (plan_i.wr && bank_act[k]),
      .waddr_i (bank_row[k]),
      .wdata_i (bank_wd[k]),
      .re_i    (plan_i.rd && bank_act[k]),
      .raddr_i (bank_row[k]),
      .rdata_o (bank_rd[k])
    );
  end

  // read lane bookkeeping, lined up with the registered RAM output
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LANES; i++) begin
        rd_on_q[i] <= 1'b0;
      end
    end else begin
      for (int i = 0; i < LANES; i++) begin
        rd_on_q[i] <= plan_i.rd && (4'(i) < plan_i.cnt);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < LANES; i++) begin
      rd_head_q[i]  <= pos[i] < PW'(NB);
      rd_hbyte_q[i] <= head_q[LBW'(pos[i] % NB)];
      rd_bsel_q[i]  <= LBW'(pos[i] % NB);
    end
  end

  always_comb begin
    rdata_o = '0;
    for (int i = 0; i < LANES; i++) begin
      if (rd_on_q[i]) begin
        rdata_o[i*BYTE_W +: BYTE_W] = rd_head_q[i] ? rd_hbyte_q[i] : bank_rd[rd_bsel_q[i]];
      end
    end
  end

endmodule
`default_nettype wire

// File: rtl/byte_ring_buffer_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// byte_ring_buffer_top
// Circular byte buffer with write, read/peek, discard, advance and clear.
// ----------------------------------------------------------------------------
// One request is taken in every clock cycle: busy never rises. The result of
// a request is shown on the result ports, marked by done_o, for exactly one
// cycle, the cycle after the request is taken; the receiver cannot stall it.
// The result is registered, in step with the registered read port of the byte
// banks. The store is split into up to eight byte-wide RAM banks (one per
// lane, rounded up to a power of two) so up to eight bytes move per request;
// the first bank-row of the store sits in flops so that a request that wraps
// round the end never needs two bytes from one bank. The store needs no
// clearing pass after reset. Writing buf_size (APB, address 0) sets the size
// in use and empties the buffer; do so only while no request is in flight.
// ----------------------------------------------------------------------------
module byte_ring_buffer_top import brb_pkg::*; #(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned LANES = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,

  // request channel
  input  logic               start,
  output logic               busy,
  input  logic [OP_W-1:0]    op_i,
  input  logic [LEN_W-1:0]   length_i,
  input  logic [DATA_W-1:0]  data_in_i,
  input  logic               consume_i,

  // result channel
  output logic               done_o,
  output logic               ok_o,
  output logic [DATA_W-1:0]  data_out_o,
  output logic [CNT_W-1:0]   readable_total_o,
  output logic [CNT_W-1:0]   writable_total_o,
  output logic [CNT_W-1:0]   readable_linear_o,
  output logic [CNT_W-1:0]   writable_linear_o,
  output logic [IDX_W-1:0]   read_index_o,
  output logic [IDX_W-1:0]   write_index_o,

  // configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [APB_DW-1:0]  pwdata,
  output logic [APB_DW-1:0]  prdata,
  output logic               pready
);

  localparam int unsigned PW = $clog2(DEPTH);

  acc_t             plan;
  stat_t            stat;
  logic [PW-1:0]    base;
  logic [LEN_W-1:0] buf_size;
  logic             cfg_we;

  // every request is taken; a request needing no result still gets one
  assign busy   = 1'b0;
  assign pready = 1'b1;

  // APB write lands at the end of the access phase
  assign cfg_we = psel && penable && pwrite && pready &&
                  (paddr[PADDR_W-1:2] == REG_BUF_SIZE);
  assign prdata = (paddr[PADDR_W-1:2] == REG_BUF_SIZE) ? APB_DW'(buf_size) : '0;

  // pointer and count logic; it also picks the store base pointer
  brb_ctrl #(
    .DEPTH (DEPTH),
    .LANES (LANES)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start && !busy),
    .op_i       (op_i),
    .length_i   (length_i),
    .consume_i  (consume_i),
    .cfg_we_i   (cfg_we),
    .cfg_data_i (pwdata[LEN_W-1:0]),
    .buf_size_o (buf_size),
    .plan_o     (plan),
    .base_o     (base),
    .done_o     (done_o),
    .stat_o     (stat)
  );

  // banked byte store and lane routing
  brb_store #(
    .DEPTH (DEPTH),
    .LANES (LANES)
  ) u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .plan_i    (plan),
    .base_i    (base),
    .data_in_i (data_in_i),
    .rdata_o   (data_out_o)
  );

  assign ok_o              = stat.ok;
  assign readable_total_o  = stat.rd_tot;
  assign writable_total_o  = stat.wr_tot;
  assign readable_linear_o = stat.rd_lin;
  assign writable_linear_o = stat.wr_lin;
  assign read_index_o      = stat.rd_idx;
  assign write_index_o     = stat.wr_idx;

endmodule
`default_nettype wire

// File: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: circular byte buffer bench
// Drives write, read/peek, discard, advance and clear requests into the ring
// buffer, predicts every result from a private model of the store, pointers
// and fill level, and compares each result field by field. Covers reset size,
// size register extremes and long random traffic over small and full sizes.
// ----------------------------------------------------------------------------
module tb_top import brb_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH       = 4096;
  localparam int unsigned LANES       = 8;
  localparam int unsigned AW          = $clog2(DEPTH);
  localparam int unsigned CYCLE_LIMIT = 200000;

  // buf_size register sits at byte address 0
  localparam logic [PADDR_W-1:0] BUF_SIZE_ADDR = PADDR_W'({REG_BUF_SIZE, 2'b00});

  // expected result: read data plus the status word from the package
  typedef struct packed {
    logic [DATA_W-1:0] data;
    stat_t             st;
  } ring_outcome_t;

  logic               clk_i;
  logic               rst_ni;
  logic               start;
  logic               busy;
  logic [OP_W-1:0]    op_i;
  logic [LEN_W-1:0]   length_i;
  logic [DATA_W-1:0]  data_in_i;
  logic               consume_i;
  logic               done_o;
  logic               ok_o;
  logic [DATA_W-1:0]  data_out_o;
  logic [CNT_W-1:0]   readable_total_o;
  logic [CNT_W-1:0]   writable_total_o;
  logic [CNT_W-1:0]   readable_linear_o;
  logic [CNT_W-1:0]   writable_linear_o;
  logic [IDX_W-1:0]   read_index_o;
  logic [IDX_W-1:0]   write_index_o;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [APB_DW-1:0]  pwdata;
  logic [APB_DW-1:0]  prdata;
  logic               pready;

  // private copy of the buffer: store contents, which bytes were ever written,
  // the two pointers, the fill level and the raw size register
  logic [7:0]       store_q    [DEPTH];
  bit               store_seen [DEPTH];
  int unsigned      rd_ptr;
  int unsigned      wr_ptr;
  int unsigned      level;
  logic [CNT_W-1:0] size_reg;

  ring_outcome_t ring_outcome_q[$];   // one entry per request in flight

  int unsigned n_errors;
  int unsigned n_sent;
  int unsigned n_accepted;
  int unsigned n_rejected;
  int unsigned n_sizes;
  int unsigned cycle_cnt;

  byte_ring_buffer_top #(
    .DEPTH(DEPTH),
    .LANES(LANES)
  ) dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .op_i             (op_i),
    .length_i         (length_i),
    .data_in_i        (data_in_i),
    .consume_i        (consume_i),
    .done_o           (done_o),
    .ok_o             (ok_o),
    .data_out_o       (data_out_o),
    .readable_total_o (readable_total_o),
    .writable_total_o (writable_total_o),
    .readable_linear_o(readable_linear_o),
    .writable_linear_o(writable_linear_o),
    .read_index_o     (read_index_o),
    .write_index_o    (write_index_o),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // watchdog: the run must finish well inside the cycle budget
  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("timeout after %0d cycles, %0d results outstanding",
             cycle_cnt, ring_outcome_q.size());
    $display("FAIL byte_ring_buffer_top");
    $finish;
  end

  task automatic report_mismatch(string what, logic [DATA_W-1:0] got,
                                 logic [DATA_W-1:0] want);
    $display("[%0t] mismatch %s: got %h want %h", $realtime, what, got, want);
    n_errors++;
  endtask

  // size in use: 0 behaves as 1, anything past the store as the whole store
  function automatic int unsigned size_in_use();
    if (size_reg == '0) return 1;
    if (size_reg > DEPTH) return DEPTH;
    return 32'(size_reg);
  endfunction

  // pointer advance with wrap to 0 at the end of the used area
  function automatic int unsigned ring_wrap(int unsigned pos, int unsigned n,
                                            int unsigned sz);
    int unsigned p;
    p = pos + n;
    if (p >= sz) p -= sz;
    if (p >= sz) p = 0;
    return p;
  endfunction

  // Applies one accepted request to the private buffer and returns the
  // result the block must show for it.
  function automatic ring_outcome_t ring_apply(logic [OP_W-1:0] op,
                                               logic [LEN_W-1:0] len,
                                               logic [DATA_W-1:0] din,
                                               logic cons);
    ring_outcome_t r;
    int unsigned   sz;
    int unsigned   room;
    int unsigned   n;
    int unsigned   p;
    int unsigned   i;
    r  = '0;
    sz = size_in_use();
    if (level > sz) level = sz;
    if (rd_ptr >= sz) rd_ptr = 0;
    if (wr_ptr >= sz) wr_ptr = 0;
    room = sz - level;
    n    = 32'(len);
    case (op)
      OP_WRITE: begin
        // all or nothing: too long or too little room leaves state alone
        if (n <= LANES && n <= room) begin
          p = wr_ptr;
          for (i = 0; i < n; i++) begin
            store_q[AW'(p)]    = din[8*i +: 8];
            store_seen[AW'(p)] = 1'b1;
            p = ring_wrap(p, 1, sz);
          end
          wr_ptr   = p;
          level   += n;
          r.st.ok  = 1'b1;
        end
      end
      OP_READ: begin
        if (n <= LANES && n <= level) begin
          p = rd_ptr;
          for (i = 0; i < n; i++) begin
            r.data[8*i +: 8] = store_q[AW'(p)];
            p = ring_wrap(p, 1, sz);
          end
          // a peek reports the bytes but leaves them in place
          if (cons) begin
            rd_ptr = p;
            level -= n;
          end
          r.st.ok = 1'b1;
        end
      end
      OP_DISCARD: begin
        if (n > level) n = level;
        rd_ptr  = ring_wrap(rd_ptr, n, sz);
        level  -= n;
        r.st.ok = 1'b1;
      end
      OP_ADVANCE: begin
        // skipped bytes keep whatever the store held before
        if (n > room) n = room;
        wr_ptr  = ring_wrap(wr_ptr, n, sz);
        level  += n;
        r.st.ok = 1'b1;
      end
      OP_CLEAR: begin
        rd_ptr  = 0;
        wr_ptr  = 0;
        level   = 0;
        r.st.ok = 1'b1;
      end
      default: ;   // unknown op: rejected, nothing moves
    endcase
    r.st.rd_tot = CNT_W'(level);
    r.st.wr_tot = CNT_W'(sz - level);
    r.st.rd_lin = CNT_W'((sz - rd_ptr < level) ? sz - rd_ptr : level);
    r.st.wr_lin = CNT_W'((sz - wr_ptr < sz - level) ? sz - wr_ptr : sz - level);
    r.st.rd_idx = IDX_W'(rd_ptr);
    r.st.wr_idx = IDX_W'(wr_ptr);
    if (r.st.ok) n_accepted++;
    else n_rejected++;
    return r;
  endfunction

  // Offer one request and hold it until taken; start stays high afterwards
  // so that back-to-back requests need no second assignment in one step.
  task automatic send_request(logic [OP_W-1:0] op, logic [LEN_W-1:0] len,
                              logic [DATA_W-1:0] din, logic cons);
    @(negedge clk_i);
    start     <= 1'b1;
    op_i      <= op;
    length_i  <= len;
    data_in_i <= din;
    consume_i <= cons;
    do @(posedge clk_i); while (busy !== 1'b0);
    ring_outcome_q.insert(ring_outcome_q.size(), ring_apply(op, len, din, cons));
    n_sent++;
  endtask

  // take start low, leaving the request side idle
  task automatic hold_start_low();
    @(negedge clk_i);
    start <= 1'b0;
  endtask

  // Stop sending and wait for every outstanding result, then a short margin
  // (each request gives exactly one result, in the cycle after it is taken).
  task automatic wait_ring_drained();
    hold_start_low();
    while (ring_outcome_q.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  // Write buf_size over APB while idle, mirror it in the model (the write
  // also empties the buffer), then read it back in a second transfer.
  task automatic set_buf_size(logic [CNT_W-1:0] value);
    logic [APB_DW-1:0] got;
    wait_ring_drained();
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= BUF_SIZE_ADDR;
    pwdata  <= APB_DW'(value);
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    size_reg = value;
    rd_ptr   = 0;
    wr_ptr   = 0;
    level    = 0;
    n_sizes++;
    // read-back follows straight on: new setup phase, psel kept high
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    got = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (got[CNT_W-1:0] !== value)
      report_mismatch("buf_size read-back", DATA_W'(got), DATA_W'(value));
  endtask

  // Field extremes and the all-or-nothing / clamping cases at reset size.
  task automatic test_request_extremes();
    int unsigned bad;
    send_request(OP_READ, '0, '0, 1'b1);                 // zero-length read, empty
    send_request(OP_READ, LEN_W'(1), '0, 1'b1);          // read with no data
    send_request(OP_WRITE, '0, '1, 1'b0);                // zero-length write
    send_request(OP_WRITE, LEN_W'(LANES), '1, 1'b0);     // every lane all ones
    send_request(OP_WRITE, LEN_W'(LANES + 1), '1, 1'b1); // too long
    send_request(OP_READ, LEN_W'(LANES), '0, 1'b0);      // peek all lanes
    send_request(OP_READ, LEN_W'(LANES + 1), '0, 1'b1);  // too long
    send_request(OP_READ, LEN_W'(LANES), '1, 1'b1);      // consume all lanes
    send_request(OP_WRITE, LEN_W'(5), 64'h0123_4567_89AB_CDEF, 1'b1);
    for (bad = int'(OP_CLEAR) + 1; bad < (1 << OP_W); bad++)
      send_request(OP_W'(bad), '1, '1, 1'b1);            // unknown ops
    send_request(OP_DISCARD, '1, '0, 1'b0);              // clamps to level
    send_request(OP_ADVANCE, '1, '0, 1'b0);              // clamps to room: full
    send_request(OP_WRITE, LEN_W'(1), '1, 1'b0);         // no room
    send_request(OP_DISCARD, LEN_W'(4000), '0, 1'b0);
    send_request(OP_CLEAR, '1, '1, 1'b1);
  endtask

  // Size register at its extremes, including the out-of-range raw values.
  task automatic test_size_extremes();
    set_buf_size(CNT_W'(1));
    send_request(OP_WRITE, LEN_W'(1), 64'hA5, 1'b0);
    send_request(OP_WRITE, LEN_W'(1), 64'h5A, 1'b0);     // single byte full
    send_request(OP_READ, LEN_W'(1), '0, 1'b0);
    send_request(OP_READ, LEN_W'(1), '0, 1'b1);
    send_request(OP_ADVANCE, '1, '0, 1'b0);
    send_request(OP_DISCARD, '1, '0, 1'b0);
    set_buf_size('0);                                    // behaves as one byte
    send_request(OP_WRITE, LEN_W'(1), 64'h3C, 1'b0);
    send_request(OP_READ, LEN_W'(1), '0, 1'b1);
    set_buf_size('1);                                    // behaves as full store
    send_request(OP_WRITE, LEN_W'(LANES), 64'hDEAD_BEEF_0BAD_F00D, 1'b0);
    send_request(OP_READ, LEN_W'(LANES), '0, 1'b0);
    set_buf_size(CNT_W'(5000));
    send_request(OP_WRITE, LEN_W'(3), 64'h00C0_FFEE, 1'b0);
    set_buf_size(CNT_W'(DEPTH));
  endtask

  // One random request, mostly well formed against the current fill level so
  // the buffer keeps filling, draining and wrapping; the rest is rejected or
  // unknown traffic. Reads never touch a store byte that was never written.
  task automatic send_random_request(int unsigned idle_pct);
    logic [OP_W-1:0]   op;
    logic [LEN_W-1:0]  len;
    logic [DATA_W-1:0] din;
    logic              cons;
    int unsigned       sz;
    int unsigned       room;
    int unsigned       pick;
    int unsigned       safe;
    int unsigned       p;
    while ($urandom_range(0, 99) < idle_pct) hold_start_low();
    sz   = size_in_use();
    room = sz - level;
    din  = {$urandom, $urandom};
    cons = 1'b1;
    pick = $urandom_range(0, 99);
    // longest read from the read pointer over written bytes only
    safe = 0;
    p    = rd_ptr;
    while (safe < LANES && safe < level && store_seen[AW'(p)]) begin
      safe++;
      p = ring_wrap(p, 1, sz);
    end
    if (pick < 38) begin
      op  = OP_WRITE;
      len = ($urandom_range(0, 9) == 0) ? LEN_W'($urandom_range(0, LANES))
                                        : LEN_W'($urandom_range(0, (room < LANES) ?
                                                                   room : LANES));
    end else if (pick < 70) begin
      op   = OP_READ;
      cons = ($urandom_range(0, 3) != 0);
      len  = ($urandom_range(0, 9) == 0) ? LEN_W'($urandom_range(0, LANES))
                                         : LEN_W'($urandom_range(0, safe));
      if (len <= level && len > safe) len = LEN_W'(safe);
    end else if (pick < 88) begin
      op = (pick < 79) ? OP_DISCARD : OP_ADVANCE;
      case ($urandom_range(0, 9))
        0:       len = LEN_W'($urandom_range(0, (1 << LEN_W) - 1));
        1, 2:    len = LEN_W'($urandom_range(0, sz));
        default: len = LEN_W'($urandom_range(0, 2 * LANES));
      endcase
    end else if (pick < 91) begin
      op  = OP_CLEAR;
      len = LEN_W'($urandom_range(0, 2 * LANES));
    end else begin
      // noise: unknown ops and over-long writes or reads
      cons = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 2))
        0:       op = OP_W'($urandom_range(int'(OP_CLEAR) + 1, (1 << OP_W) - 1));
        1:       op = OP_WRITE;
        default: op = OP_READ;
      endcase
      len = LEN_W'($urandom_range(LANES + 1, (1 << LEN_W) - 1));
    end
    send_request(op, len, din, cons);
  endtask

  // Random traffic in segments of one size each: a single byte, tiny, small,
  // medium and the full store, with occasional full drains in between.
  task automatic test_random_traffic(int unsigned idle_pct, int unsigned count);
    int unsigned i;
    int unsigned sz;
    for (i = 0; i < count; i++) begin
      if (i % 120 == 0) begin
        case ((i / 120) % 5)
          0:       sz = 1;
          1:       sz = $urandom_range(2, 9);
          2:       sz = $urandom_range(10, 40);
          3:       sz = $urandom_range(41, 300);
          default: sz = DEPTH;
        endcase
        set_buf_size(CNT_W'(sz));
      end else if ($urandom_range(0, 199) == 0) begin
        wait_ring_drained();
      end
      send_random_request(idle_pct);
    end
  endtask

  // Result checker: each strobed result against the oldest prediction.
  always @(posedge clk_i) begin
    ring_outcome_t want;
    if (rst_ni && done_o === 1'b1) begin
      if (ring_outcome_q.size() == 0) begin
        report_mismatch("result with no request outstanding", data_out_o, '0);
      end else begin
        want = ring_outcome_q[0];
        ring_outcome_q.delete(0);
        if (ok_o !== want.st.ok)
          report_mismatch("ok", DATA_W'(ok_o), DATA_W'(want.st.ok));
        if (data_out_o !== want.data)
          report_mismatch("data_out", data_out_o, want.data);
        if (readable_total_o !== want.st.rd_tot)
          report_mismatch("readable_total", DATA_W'(readable_total_o),
                          DATA_W'(want.st.rd_tot));
        if (writable_total_o !== want.st.wr_tot)
          report_mismatch("writable_total", DATA_W'(writable_total_o),
                          DATA_W'(want.st.wr_tot));
        if (readable_linear_o !== want.st.rd_lin)
          report_mismatch("readable_linear", DATA_W'(readable_linear_o),
                          DATA_W'(want.st.rd_lin));
        if (writable_linear_o !== want.st.wr_lin)
          report_mismatch("writable_linear", DATA_W'(writable_linear_o),
                          DATA_W'(want.st.wr_lin));
        if (read_index_o !== want.st.rd_idx)
          report_mismatch("read_index", DATA_W'(read_index_o), DATA_W'(want.st.rd_idx));
        if (write_index_o !== want.st.wr_idx)
          report_mismatch("write_index", DATA_W'(write_index_o), DATA_W'(want.st.wr_idx));
      end
    end
  end

  initial begin
    rst_ni     = 1'b0;
    start      = 1'b0;
    op_i       = OP_CLEAR;
    length_i   = '0;
    data_in_i  = '0;
    consume_i  = 1'b0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    rd_ptr     = 0;
    wr_ptr     = 0;
    level      = 0;
    size_reg   = CNT_W'(DEPTH);
    n_errors   = 0;
    n_sent     = 0;
    n_accepted = 0;
    n_rejected = 0;
    n_sizes    = 0;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_request_extremes();
    test_size_extremes();
    test_random_traffic(32, 600);   // sender gaps about a third of the time
    test_random_traffic(60, 600);   // sender gaps more often than not
    test_random_traffic(0, 600);    // back to back throughout

    wait_ring_drained();
    repeat (4) @(posedge clk_i);
    if (ring_outcome_q.size() != 0)
      report_mismatch("results never delivered", DATA_W'(ring_outcome_q.size()), '0);

    $display("covered %0d requests (%0d accepted, %0d rejected) over %0d size settings",
             n_sent, n_accepted, n_rejected, n_sizes);
    $display("mismatches: %0d", n_errors);
    if (n_errors == 0) begin
      $display("PASS byte_ring_buffer_top");
    end else begin
      $display("FAIL byte_ring_buffer_top");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/brb_pkg.sv
rtl/brb_ram.sv
rtl/brb_ctrl.sv
rtl/brb_store.sv
rtl/byte_ring_buffer_top.sv
bench/tb_top.sv
